// ----- rtl/jbt_pkg.sv -----
// Package for the JSON byte tokenizer: result record, token kinds, error codes,
// lexer modes, byte constants and the keyword tables.
// No dependencies.
package jbt_pkg;

  typedef enum logic [3:0] {
    KIND_OBJ_OPEN  = 4'd0,
    KIND_OBJ_CLOSE = 4'd1,
    KIND_ARR_OPEN  = 4'd2,
    KIND_ARR_CLOSE = 4'd3,
    KIND_COLON     = 4'd4,
    KIND_COMMA     = 4'd5,
    KIND_STRING    = 4'd6,
    KIND_NUMBER    = 4'd7,
    KIND_BOOL      = 4'd8,
    KIND_NULL      = 4'd9,
    KIND_DONE      = 4'd10,
    KIND_ERROR     = 4'd11
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNCLOSED  = 3'd1,
    ERR_BAD_LIT   = 3'd2,
    ERR_UNEXPECT  = 3'd3,
    ERR_TOO_LONG  = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_LITERAL = 2'd2,
    MODE_NUMBER  = 2'd3
  } mode_e;

  localparam int unsigned FieldW  = 16;
  localparam int unsigned MaxPush = 3;

  typedef struct packed {
    kind_e              kind;
    err_e               code;
    logic [FieldW-1:0]  start;
    logic [FieldW-1:0]  len;
    logic               last;
  } result_t;

  // Results produced by one request, in order, slots [0 .. cnt-1] valid.
  typedef struct packed {
    logic [1:0]          cnt;
    result_t [MaxPush-1:0] res;
  } push_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  function automatic logic is_num(input logic [7:0] b);
    is_num = (b == CH_MINUS) || (b == CH_DOT) || ((b >= CH_ZERO) && (b <= CH_NINE));
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] sel);
    lit_len = (sel == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic kind_e lit_kind(input logic [1:0] sel);
    lit_kind = (sel == LIT_TRUE || sel == LIT_FALSE) ? KIND_BOOL : KIND_NULL;
  endfunction

  // Expected character of a keyword at a position; 0 past the end.
  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [39:0] txt;
    txt = '0;
    unique case (sel)
      LIT_TRUE:  txt = {8'h74, 8'h72, 8'h75, 8'h65, 8'h00};
      LIT_FALSE: txt = {8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
      default:   txt = {8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00};
    endcase
    unique case (pos)
      3'd0:    lit_char = txt[39:32];
      3'd1:    lit_char = txt[31:24];
      3'd2:    lit_char = txt[23:16];
      3'd3:    lit_char = txt[15:8];
      3'd4:    lit_char = txt[7:0];
      default: lit_char = 8'h00;
    endcase
  endfunction

  function automatic result_t mk_res(input kind_e kind, input err_e code,
                                     input logic [FieldW-1:0] start,
                                     input logic [FieldW-1:0] len, input logic last);
    mk_res.kind  = kind;
    mk_res.code  = code;
    mk_res.start = start;
    mk_res.len   = len;
    mk_res.last  = last;
  endfunction

endpackage

// ----- rtl/jbt_core.sv -----
// Lexer state and per-byte decode: turns one accepted byte into up to three results.
// Depends on jbt_pkg.
module jbt_core #(
  parameter int unsigned MAX_MESSAGE_BYTES = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_message_i,
  output jbt_pkg::push_t push_o
);
  import jbt_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_MESSAGE_BYTES);

  mode_e           mode_q, mode_d;
  logic            esc_q, esc_d;
  logic [1:0]      lsel_q, lsel_d;
  logic [2:0]      lpos_q, lpos_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] begin_q, begin_d;
  logic            drop_q, drop_d;

  always_comb begin
    logic [1:0]      n;
    result_t [MaxPush-1:0] res;
    err_e            err;
    logic [PosW-1:0] err_start;
    logic [PosW-1:0] pos_nx;
    logic [2:0]      lpos_nx;
    logic            clear;

    mode_d    = mode_q;
    esc_d     = esc_q;
    lsel_d    = lsel_q;
    lpos_d    = lpos_q;
    pos_d     = pos_q;
    begin_d   = begin_q;
    drop_d    = drop_q;
    n         = 2'd0;
    res       = '0;
    err       = ERR_NONE;
    err_start = '0;
    pos_nx    = pos_q + PosW'(1);
    lpos_nx   = lpos_q + 3'd1;
    clear     = 1'b0;

    if (fire_i) begin
      if (drop_q) begin
        clear = end_of_message_i;
      end else begin
        if (pos_q >= MaxPos) begin
          err       = ERR_TOO_LONG;
          err_start = pos_q;
        end else begin
          unique case (mode_q)
            MODE_STRING: begin
              if (esc_q) begin
                esc_d = 1'b0;
              end else if (data_byte_i == CH_BSLASH) begin
                esc_d = 1'b1;
              end else if (data_byte_i == CH_QUOTE) begin
                res[n] = mk_res(KIND_STRING, ERR_NONE, FieldW'(begin_q),
                                FieldW'(pos_nx - begin_q), 1'b0);
                n      = n + 2'd1;
                mode_d = MODE_IDLE;
              end
            end
            MODE_LITERAL: begin
              if ((lpos_q < lit_len(lsel_q)) &&
                  (data_byte_i == lit_char(lsel_q, lpos_q))) begin
                lpos_d = lpos_nx;
                if (lpos_nx == lit_len(lsel_q)) begin
                  res[n] = mk_res(lit_kind(lsel_q), ERR_NONE, FieldW'(begin_q),
                                  FieldW'(lit_len(lsel_q)), 1'b0);
                  n      = n + 2'd1;
                  mode_d = MODE_IDLE;
                  lpos_d = 3'd0;
                end
              end else begin
                err       = ERR_BAD_LIT;
                err_start = begin_q;
              end
            end
            default: begin
              // A number closes on the first byte outside its set; that byte
              // is then decoded as if between tokens.
              if (mode_q == MODE_NUMBER && !is_num(data_byte_i)) begin
                res[n] = mk_res(KIND_NUMBER, ERR_NONE, FieldW'(begin_q),
                                FieldW'(pos_q - begin_q), 1'b0);
                n      = n + 2'd1;
                mode_d = MODE_IDLE;
              end
              if (mode_d == MODE_IDLE) begin
                priority case (data_byte_i)
                  CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_COMMA: begin
                    priority case (data_byte_i)
                      CH_LBRACE: res[n] = mk_res(KIND_OBJ_OPEN, ERR_NONE, FieldW'(pos_q),
                                                 FieldW'(1), 1'b0);
                      CH_RBRACE: res[n] = mk_res(KIND_OBJ_CLOSE, ERR_NONE, FieldW'(pos_q),
                                                 FieldW'(1), 1'b0);
                      CH_LBRACK: res[n] = mk_res(KIND_ARR_OPEN, ERR_NONE, FieldW'(pos_q),
                                                 FieldW'(1), 1'b0);
                      CH_RBRACK: res[n] = mk_res(KIND_ARR_CLOSE, ERR_NONE, FieldW'(pos_q),
                                                 FieldW'(1), 1'b0);
                      CH_COLON:  res[n] = mk_res(KIND_COLON, ERR_NONE, FieldW'(pos_q),
                                                 FieldW'(1), 1'b0);
                      default:   res[n] = mk_res(KIND_COMMA, ERR_NONE, FieldW'(pos_q),
                                                 FieldW'(1), 1'b0);
                    endcase
                    n = n + 2'd1;
                  end
                  CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
                  CH_QUOTE: begin
                    mode_d  = MODE_STRING;
                    esc_d   = 1'b0;
                    begin_d = pos_q;
                  end
                  CH_T, CH_F, CH_N: begin
                    mode_d  = MODE_LITERAL;
                    lsel_d  = (data_byte_i == CH_T) ? LIT_TRUE :
                              (data_byte_i == CH_F) ? LIT_FALSE : LIT_NULL;
                    lpos_d  = 3'd1;
                    begin_d = pos_q;
                  end
                  default: begin
                    if (is_num(data_byte_i)) begin
                      mode_d  = MODE_NUMBER;
                      begin_d = pos_q;
                    end else begin
                      err       = ERR_UNEXPECT;
                      err_start = pos_q;
                    end
                  end
                endcase
              end
            end
          endcase
        end

        if (err != ERR_NONE) begin
          res[n] = mk_res(KIND_ERROR, err, FieldW'(err_start), '0, 1'b1);
          n      = n + 2'd1;
          if (end_of_message_i) clear = 1'b1;
          else                  drop_d = 1'b1;
        end else begin
          pos_d = pos_nx;
          if (end_of_message_i) begin
            unique case (mode_d)
              MODE_NUMBER: begin
                res[n] = mk_res(KIND_NUMBER, ERR_NONE, FieldW'(begin_d),
                                FieldW'(pos_nx - begin_d), 1'b0);
                n      = n + 2'd1;
                res[n] = mk_res(KIND_DONE, ERR_NONE, FieldW'(pos_nx), '0, 1'b1);
              end
              MODE_STRING:
                res[n] = mk_res(KIND_ERROR, ERR_UNCLOSED, FieldW'(begin_d), '0, 1'b1);
              MODE_LITERAL:
                res[n] = mk_res(KIND_ERROR, ERR_BAD_LIT, FieldW'(begin_d), '0, 1'b1);
              default:
                res[n] = mk_res(KIND_DONE, ERR_NONE, FieldW'(pos_nx), '0, 1'b1);
            endcase
            n     = n + 2'd1;
            clear = 1'b1;
          end
        end
      end
    end

    if (clear) begin
      mode_d  = MODE_IDLE;
      esc_d   = 1'b0;
      lsel_d  = 2'd0;
      lpos_d  = 3'd0;
      pos_d   = '0;
      begin_d = '0;
      drop_d  = 1'b0;
    end

    push_o.cnt = n;
    push_o.res = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      esc_q   <= 1'b0;
      lsel_q  <= 2'd0;
      lpos_q  <= 3'd0;
      pos_q   <= '0;
      begin_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      esc_q   <= esc_d;
      lsel_q  <= lsel_d;
      lpos_q  <= lpos_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      drop_q  <= drop_d;
    end
  end

endmodule

// ----- rtl/jbt_fifo.sv -----
// Four-entry result queue: takes up to three results per cycle, hands out one.
// Depends on jbt_pkg.
module jbt_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jbt_pkg::push_t   push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output jbt_pkg::result_t data_o
);
  import jbt_pkg::*;

  localparam int unsigned Depth = 4;

  result_t    mem_q [Depth];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  // Room for a worst-case request regardless of what leaves this cycle.
  assign room_o  = (cnt_q <= 3'(Depth - MaxPush));

  always_comb begin
    wr_d  = wr_q + push_i.cnt;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_i.cnt} - {2'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxPush; i++) begin
      if (2'(i) < push_i.cnt) mem_q[wr_q + 2'(i)] <= push_i.res[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/json_byte_tokenizer.sv -----
// Top level of the streaming JSON byte tokenizer.
// Depends on jbt_pkg, jbt_core and jbt_fifo.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one byte of JSON text per
//   request, with end_of_message_i set on the final byte of a message.
//   Output channel (out_valid_o / out_ready_i) carries one token record per
//   request: kind, error code, start offset, length and the last-of-message
//   flag that marks the done or error record closing a message.
//   The records of an accepted byte are written into the result queue, the one
//   register stage, and reach the output behind any older records.
//   Throughput: one byte per cycle while bytes yield at most one record each and
//   the receiver is ready. A byte can yield up to three records (number close,
//   punctuation, done); the output drains one per cycle, so the input pauses
//   for the extra ones. in_ready_o is high while the four-entry queue has room
//   for three records. Reset clears the lexer to between tokens at offset zero
//   and empties the queue. When the receiver stalls, records hold in the queue
//   and the input stops once the queue lacks room for a worst-case byte.
//   After an error, bytes are taken and dropped until the end of the message.
module json_byte_tokenizer #(
  parameter int unsigned MAX_MESSAGE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        last_of_message_o
);
  import jbt_pkg::*;

  push_t   push;
  result_t head;
  logic    room;
  logic    fire;

  // Take a byte only when the queue can absorb everything it may produce.
  assign in_ready_o = room;
  assign fire       = in_valid_i && room;

  jbt_core #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .data_byte_i     (data_byte_i),
    .end_of_message_i(end_of_message_i),
    .push_o          (push)
  );

  jbt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (head)
  );

  assign token_kind_o      = head.kind;
  assign error_code_o      = head.code;
  assign token_start_o     = head.start;
  assign token_length_o    = head.len;
  assign last_of_message_o = head.last;

endmodule
